[rtl/core/lcd_timing_register_block_defines.svh]
// ----------------------------------------------------------------------------
// lcd timing register block assertion macros
// shared assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef LCD_TIMING_REGISTER_BLOCK_DEFINES_SVH
`define LCD_TIMING_REGISTER_BLOCK_DEFINES_SVH
`ifndef SYNTH
// plain property checked on every edge out of reset
`define LCDT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// same-cycle implication
`define LCDT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define LCDT_ASSERT(lbl, clk, rst_n, prop, msg)
`define LCDT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/core/lcdt_pkg.sv]
// ----------------------------------------------------------------------------
// lcd timing package
// command and mode codes, register addresses and palette sizing
// ----------------------------------------------------------------------------
package lcdt_pkg;

  // item commands
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // display modes
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_SEARCH = 2'd2;
  localparam logic [1:0] MODE_XFER   = 2'd3;

  // mode boundaries within a visible line
  localparam logic [8:0] SEARCH_END_DOT = 9'd80;
  localparam logic [8:0] XFER_END_DOT   = 9'd252;

  // register map
  localparam logic [15:0] ADDR_LCDC = 16'hFF40;
  localparam logic [15:0] ADDR_STAT = 16'hFF41;
  localparam logic [15:0] ADDR_SCY  = 16'hFF42;
  localparam logic [15:0] ADDR_SCX  = 16'hFF43;
  localparam logic [15:0] ADDR_LY   = 16'hFF44;
  localparam logic [15:0] ADDR_LYC  = 16'hFF45;
  localparam logic [15:0] ADDR_BGP  = 16'hFF47;
  localparam logic [15:0] ADDR_OBP0 = 16'hFF48;
  localparam logic [15:0] ADDR_OBP1 = 16'hFF49;
  localparam logic [15:0] ADDR_WY   = 16'hFF4A;
  localparam logic [15:0] ADDR_WX   = 16'hFF4B;
  localparam logic [15:0] ADDR_VBK  = 16'hFF4F;
  localparam logic [15:0] ADDR_BGPI = 16'hFF68;
  localparam logic [15:0] ADDR_BGPD = 16'hFF69;
  localparam logic [15:0] ADDR_OBPI = 16'hFF6A;
  localparam logic [15:0] ADDR_OBPD = 16'hFF6B;

  // reset values and fill byte
  localparam logic [7:0] LCDC_RESET = 8'h91;
  localparam logic [6:0] STAT_RESET = 7'h05;
  localparam logic [7:0] BGP_RESET  = 8'hFC;
  localparam logic [7:0] FILL_BYTE  = 8'hFF;

  // colour palette memory
  localparam int PAL_BYTES = 64;
  localparam int PAL_AW    = $clog2(PAL_BYTES);

  // palette update request for one committed item
  typedef struct packed {
    logic       idx_we;
    logic       data_we;
    logic [7:0] wdata;
  } pal_req_t;

endpackage

[rtl/core/lcdt_ram.sv]
// ----------------------------------------------------------------------------
// lcdt generic ram
// single write port, single read port with registered read data
// ----------------------------------------------------------------------------
module lcdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/lcdt_palette.sv]
// ----------------------------------------------------------------------------
// lcdt colour palette bank
// index register with auto-increment, palette ram, per-entry valid bits
// and write-to-read forwarding
// ----------------------------------------------------------------------------
module lcdt_palette
  import lcdt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     commit,
  input  pal_req_t req,
  input  logic     rd_en,
  output logic [7:0] index,
  output logic [7:0] rd_data
);

  logic [7:0]          index_r;
  logic [7:0]          index_nxt;
  logic [PAL_BYTES-1:0] valid_r;
  logic                ram_we;
  logic [PAL_AW-1:0]   waddr;
  logic [PAL_AW-1:0]   raddr;
  logic [7:0]          ram_q;
  logic                rd_vld_r;
  logic                byp_hit_r;
  logic [7:0]          byp_data_r;

  assign ram_we = commit & req.data_we;
  assign waddr  = index_r[PAL_AW-1:0];

  // index update: direct write masked, post-increment on data write when bit 7 is set
  always_comb begin
    index_nxt = index_r;
    if (commit && req.idx_we) begin
      index_nxt = req.wdata & 8'hBF;
    end else if (ram_we && index_r[7]) begin
      index_nxt = {1'b1, 1'b0, index_r[PAL_AW-1:0] + PAL_AW'(1)};
    end
  end

  // read at the index as it stands after the item committing now
  assign raddr = index_nxt[PAL_AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_r <= '0;
      valid_r <= '0;
    end else begin
      index_r <= index_nxt;
      if (ram_we) begin
        valid_r[waddr] <= 1'b1;
      end
    end
  end

  // valid and forwarding info captured alongside the ram read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_vld_r   <= valid_r[raddr];
      byp_hit_r  <= ram_we && (waddr == raddr);
      byp_data_r <= req.wdata;
    end
  end

  lcdt_ram #(
    .WIDTH(8),
    .DEPTH(PAL_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr),
    .wdata(req.wdata),
    .re   (rd_en),
    .raddr(raddr),
    .rdata(ram_q)
  );

  assign index   = index_r;
  assign rd_data = byp_hit_r ? byp_data_r : (rd_vld_r ? ram_q : FILL_BYTE);

endmodule

[rtl/core/lcd_timing_register_block.sv]
// ----------------------------------------------------------------------------
// lcd timing register block
// dot and line timing, mode sequencing, stat interrupt and register file
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       slave      in_tvalid / in_tready  tuser command, tdata addr and data
//  out      master     out_tvalid/out_tready  tdata one result per item
//  cfg      slave      cfg_valid / cfg_ready  cfg_data colour mode enable
//
//  one item per cycle while out_tready stays high; each item passes an input
//  register and then a result register.
//  reset is synchronous; palette entries are tracked by valid flops, so no
//  clearing pass is needed and items are taken from the first cycle on.
//  when out_tready is low the result holds, the input register takes one
//  more item and then in_tready drops.
// ----------------------------------------------------------------------------
`include "lcd_timing_register_block_defines.svh"

module lcd_timing_register_block
  import lcdt_pkg::*;
#(
  parameter int DOTS_PER_LINE = 456,
  parameter int TOTAL_LINES   = 154,
  parameter int VISIBLE_LINES = 144
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] reg_addr, [23:16] write_data
  input  logic [1:0]  in_tuser,   // [1:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] read_data, [8] vblank_irq, [9] stat_irq, [10] vblank_irq again,
  // [11] hblank_start, [19:12] current_line, [21:20] current_mode, rest 0
  output logic [23:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  localparam logic [8:0] DOTS_W    = 9'(DOTS_PER_LINE);
  localparam logic [7:0] TOTAL_W   = 8'(TOTAL_LINES);
  localparam logic [7:0] VISIBLE_W = 8'(VISIBLE_LINES);

  // input register
  logic        s1_valid_r;
  logic [1:0]  s1_cmd_r;
  logic [15:0] s1_addr_r;
  logic [7:0]  s1_data_r;
  logic        in_fire;
  logic        s1_fire;

  // state
  logic       color_mode_r;
  logic [7:0] lcd_control_r, lcd_control_nxt;
  logic [6:0] status_bits_r, status_bits_nxt;
  logic [7:0] scroll_y_r, scroll_y_nxt;
  logic [7:0] scroll_x_r, scroll_x_nxt;
  logic [7:0] line_counter_r, line_counter_nxt;
  logic [7:0] line_compare_r, line_compare_nxt;
  logic [7:0] bg_palette_r, bg_palette_nxt;
  logic [7:0] obj_palette_a_r, obj_palette_a_nxt;
  logic [7:0] obj_palette_b_r, obj_palette_b_nxt;
  logic [7:0] window_y_r, window_y_nxt;
  logic [7:0] window_x_r, window_x_nxt;
  logic       vram_bank_r, vram_bank_nxt;
  logic [8:0] dot_counter_r, dot_counter_nxt;
  logic       stat_level_r, stat_level_nxt;

  // result register
  logic        out_valid_r;
  logic [7:0]  read_data_r, read_data_nxt;
  logic        vblank_irq_r, vblank_irq_nxt;
  logic        stat_irq_r, stat_irq_nxt;
  logic        hblank_start_r, hblank_start_nxt;
  logic [7:0]  line_out_r;
  logic [1:0]  mode_out_r;

  // tick datapath
  logic       tick;
  logic [8:0] dot_inc;
  logic       wrap;
  logic [8:0] dot_t;
  logic [7:0] line_inc;
  logic [7:0] line_t;
  logic       enter_vbl;
  logic [1:0] mode_a;
  logic       match;
  logic       cond1, cond2;
  logic       level1;
  logic [1:0] new_mode;
  logic       mode_chg;

  // palette banks
  pal_req_t   bg_req, obj_req;
  logic [7:0] bg_index, obj_index;
  logic [7:0] bg_rd, obj_rd;
  logic       is_write;

  function automatic logic stat_cond(input logic [6:0] st, input logic m_hit,
                                     input logic [1:0] md);
    stat_cond = (st[6] && m_hit) || (st[3] && (md == MODE_HBLANK)) ||
                (st[4] && (md == MODE_VBLANK)) || (st[5] && (md == MODE_SEARCH));
  endfunction

  // handshake
  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r  <= in_tuser;
      s1_addr_r <= in_tdata[15:0];
      s1_data_r <= in_tdata[23:16];
    end
  end

  // dot and line advance for one tick
  always_comb begin
    tick      = (s1_cmd_r == CMD_TICK) && lcd_control_r[7];
    dot_inc   = dot_counter_r + 9'd1;
    wrap      = (dot_inc >= DOTS_W) || (dot_inc == 9'd0);
    dot_t     = wrap ? 9'd0 : dot_inc;
    line_inc  = line_counter_r + 8'd1;
    line_t    = wrap ? ((line_inc >= TOTAL_W) ? 8'd0 : line_inc) : line_counter_r;
    enter_vbl = wrap && (line_t == VISIBLE_W);
    mode_a    = enter_vbl ? MODE_VBLANK : status_bits_r[1:0];
    match     = (line_t == line_compare_r);
    cond1     = stat_cond(status_bits_r, match, mode_a);
    level1    = wrap ? cond1 : stat_level_r;
    if (dot_t < SEARCH_END_DOT) begin
      new_mode = MODE_SEARCH;
    end else if (dot_t < XFER_END_DOT) begin
      new_mode = MODE_XFER;
    end else begin
      new_mode = MODE_HBLANK;
    end
    mode_chg = (line_t < VISIBLE_W) && (new_mode != mode_a);
    cond2    = stat_cond(status_bits_r, match, new_mode);
  end

  // next state and result for the item in the input register
  always_comb begin
    lcd_control_nxt   = lcd_control_r;
    status_bits_nxt   = status_bits_r;
    scroll_y_nxt      = scroll_y_r;
    scroll_x_nxt      = scroll_x_r;
    line_counter_nxt  = line_counter_r;
    line_compare_nxt  = line_compare_r;
    bg_palette_nxt    = bg_palette_r;
    obj_palette_a_nxt = obj_palette_a_r;
    obj_palette_b_nxt = obj_palette_b_r;
    window_y_nxt      = window_y_r;
    window_x_nxt      = window_x_r;
    vram_bank_nxt     = vram_bank_r;
    dot_counter_nxt   = dot_counter_r;
    stat_level_nxt    = stat_level_r;
    read_data_nxt     = 8'd0;
    vblank_irq_nxt    = 1'b0;
    stat_irq_nxt      = 1'b0;
    hblank_start_nxt  = 1'b0;
    if (tick) begin
      dot_counter_nxt  = dot_t;
      line_counter_nxt = line_t;
      vblank_irq_nxt   = enter_vbl;
      stat_irq_nxt     = (wrap && cond1 && !stat_level_r) ||
                         (mode_chg && cond2 && !level1);
      stat_level_nxt   = mode_chg ? cond2 : level1;
      hblank_start_nxt = mode_chg && (new_mode == MODE_HBLANK);
      status_bits_nxt  = {status_bits_r[6:3],
                          (wrap || mode_chg) ? match : status_bits_r[2],
                          mode_chg ? new_mode : mode_a};
    end else if (s1_cmd_r == CMD_READ) begin
      unique case (s1_addr_r)
        ADDR_LCDC: read_data_nxt = lcd_control_r;
        ADDR_STAT: read_data_nxt = {1'b1, status_bits_r};
        ADDR_SCY:  read_data_nxt = scroll_y_r;
        ADDR_SCX:  read_data_nxt = scroll_x_r;
        ADDR_LY:   read_data_nxt = line_counter_r;
        ADDR_LYC:  read_data_nxt = line_compare_r;
        ADDR_BGP:  read_data_nxt = bg_palette_r;
        ADDR_OBP0: read_data_nxt = obj_palette_a_r;
        ADDR_OBP1: read_data_nxt = obj_palette_b_r;
        ADDR_WY:   read_data_nxt = window_y_r;
        ADDR_WX:   read_data_nxt = window_x_r;
        ADDR_VBK:  read_data_nxt = color_mode_r ? {7'h7F, vram_bank_r} : FILL_BYTE;
        ADDR_BGPI: read_data_nxt = color_mode_r ? (bg_index | 8'h40) : FILL_BYTE;
        ADDR_BGPD: read_data_nxt = color_mode_r ? bg_rd : FILL_BYTE;
        ADDR_OBPI: read_data_nxt = color_mode_r ? (obj_index | 8'h40) : FILL_BYTE;
        ADDR_OBPD: read_data_nxt = color_mode_r ? obj_rd : FILL_BYTE;
        default:   read_data_nxt = FILL_BYTE;
      endcase
    end else if (s1_cmd_r == CMD_WRITE) begin
      unique case (s1_addr_r)
        ADDR_LCDC: begin
          lcd_control_nxt = s1_data_r;
          // switching off parks the timing at line 0, mode 0
          if (lcd_control_r[7] && !s1_data_r[7]) begin
            line_counter_nxt     = 8'd0;
            dot_counter_nxt      = 9'd0;
            status_bits_nxt[1:0] = MODE_HBLANK;
          end
        end
        ADDR_STAT: status_bits_nxt = {s1_data_r[6:3], status_bits_r[2:0]};
        ADDR_SCY:  scroll_y_nxt = s1_data_r;
        ADDR_SCX:  scroll_x_nxt = s1_data_r;
        ADDR_LYC:  line_compare_nxt = s1_data_r;
        ADDR_BGP:  bg_palette_nxt = s1_data_r;
        ADDR_OBP0: obj_palette_a_nxt = s1_data_r;
        ADDR_OBP1: obj_palette_b_nxt = s1_data_r;
        ADDR_WY:   window_y_nxt = s1_data_r;
        ADDR_WX:   window_x_nxt = s1_data_r;
        ADDR_VBK:  vram_bank_nxt = color_mode_r ? s1_data_r[0] : vram_bank_r;
        default:   vram_bank_nxt = vram_bank_r;
      endcase
    end
  end

  // palette requests, only in colour mode
  assign is_write        = (s1_cmd_r == CMD_WRITE) && color_mode_r;
  assign bg_req.idx_we   = is_write && (s1_addr_r == ADDR_BGPI);
  assign bg_req.data_we  = is_write && (s1_addr_r == ADDR_BGPD);
  assign bg_req.wdata    = s1_data_r;
  assign obj_req.idx_we  = is_write && (s1_addr_r == ADDR_OBPI);
  assign obj_req.data_we = is_write && (s1_addr_r == ADDR_OBPD);
  assign obj_req.wdata   = s1_data_r;

  lcdt_palette u_bg_pal (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (s1_fire),
    .req    (bg_req),
    .rd_en  (in_fire),
    .index  (bg_index),
    .rd_data(bg_rd)
  );

  lcdt_palette u_obj_pal (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (s1_fire),
    .req    (obj_req),
    .rd_en  (in_fire),
    .index  (obj_index),
    .rd_data(obj_rd)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      color_mode_r <= cfg_data;
    end
  end

  // state commit when an item moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcd_control_r   <= LCDC_RESET;
      status_bits_r   <= STAT_RESET;
      scroll_y_r      <= 8'd0;
      scroll_x_r      <= 8'd0;
      line_counter_r  <= 8'd0;
      line_compare_r  <= 8'd0;
      bg_palette_r    <= BGP_RESET;
      obj_palette_a_r <= FILL_BYTE;
      obj_palette_b_r <= FILL_BYTE;
      window_y_r      <= 8'd0;
      window_x_r      <= 8'd0;
      vram_bank_r     <= 1'b0;
      dot_counter_r   <= 9'd0;
      stat_level_r    <= 1'b0;
    end else if (s1_fire) begin
      lcd_control_r   <= lcd_control_nxt;
      status_bits_r   <= status_bits_nxt;
      scroll_y_r      <= scroll_y_nxt;
      scroll_x_r      <= scroll_x_nxt;
      line_counter_r  <= line_counter_nxt;
      line_compare_r  <= line_compare_nxt;
      bg_palette_r    <= bg_palette_nxt;
      obj_palette_a_r <= obj_palette_a_nxt;
      obj_palette_b_r <= obj_palette_b_nxt;
      window_y_r      <= window_y_nxt;
      window_x_r      <= window_x_nxt;
      vram_bank_r     <= vram_bank_nxt;
      dot_counter_r   <= dot_counter_nxt;
      stat_level_r    <= stat_level_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      read_data_r    <= read_data_nxt;
      vblank_irq_r   <= vblank_irq_nxt;
      stat_irq_r     <= stat_irq_nxt;
      hblank_start_r <= hblank_start_nxt;
      line_out_r     <= line_counter_nxt;
      mode_out_r     <= status_bits_nxt[1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, mode_out_r, line_out_r, hblank_start_r, vblank_irq_r,
                       stat_irq_r, vblank_irq_r, read_data_r};

  // checks on timing state and results
  `LCDT_ASSERT(a_line_range, clk, rst_n, line_counter_r < TOTAL_W, "line out of range")
  `LCDT_ASSERT(a_dot_range, clk, rst_n, dot_counter_r < DOTS_W, "dot out of range")
  `LCDT_ASSERT_IMPL(a_vbl_mode, clk, rst_n, line_counter_r >= VISIBLE_W, status_bits_r[1:0] == MODE_VBLANK, "vblank line not in mode 1")
  `LCDT_ASSERT_IMPL(a_vbl_out, clk, rst_n, out_valid_r && vblank_irq_r, line_out_r == VISIBLE_W, "vblank pulse off line")
  `LCDT_ASSERT_IMPL(a_hbl_out, clk, rst_n, out_valid_r && hblank_start_r, mode_out_r == MODE_HBLANK, "hblank pulse not in mode 0")

endmodule
